FILE: design/phc_pkg.sv
`default_nettype none
package phc_pkg;

  // field widths
  localparam int VoltW  = 24;
  localparam int TempW  = 15;
  localparam int PhW    = 14;
  localparam int StW    = 2;
  localparam int CalVW  = 22;
  localparam int CalPW  = 14;

  // datapath widths
  localparam int DW    = 30;  // 3*sum(p^2) - sum(p)^2, never negative
  localparam int NW    = 39;  // 3*sum(pv) - sum(p)*sum(v), signed
  localparam int SpW   = 16;
  localparam int SvW   = 24;
  localparam int KW    = 16;  // absolute temperature in centi-kelvin
  localparam int XW    = 26;  // 3*V - sum(v), signed
  localparam int NumW  = 57;  // numerator, signed
  localparam int AW    = 56;  // numerator magnitude
  localparam int DenW  = 40;  // 3*|N|
  localparam int DivXW = 72;  // dividend |num| * calK
  localparam int DivYW = 56;  // divisor 3*|N| * tempK

  localparam logic [KW-1:0]    KELVIN_CC   = 16'd27315;
  localparam logic [CalVW-1:0] VOLT_MAX_UV = 22'd2500000;
  localparam logic [PhW-1:0]   PH_MAX      = 14'd14000;

  // status codes
  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_RANGE = 2'd1;
  localparam logic [StW-1:0] ST_DEGEN = 2'd2;

  // register indexes
  localparam logic [2:0] REG_VOLT_1   = 3'd0;
  localparam logic [2:0] REG_PH_1     = 3'd1;
  localparam logic [2:0] REG_VOLT_2   = 3'd2;
  localparam logic [2:0] REG_PH_2     = 3'd3;
  localparam logic [2:0] REG_VOLT_3   = 3'd4;
  localparam logic [2:0] REG_PH_3     = 3'd5;
  localparam logic [2:0] REG_CAL_TEMP = 3'd6;

  // fitted line, shared by every sample
  typedef struct packed {
    logic        [DW-1:0]  d;
    logic signed [NW-1:0]  n;
    logic        [SpW-1:0] sp;
    logic        [SvW-1:0] sv;
    logic        [KW-1:0]  ck;
  } phc_fit_t;

  // per-sample exception flags
  typedef struct packed {
    logic oor;
    logic degen;
    logic zero;
  } phc_flags_t;

endpackage
`default_nettype wire

FILE: design/phc_if.sv
`default_nettype none
// sample channel
interface phc_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [phc_pkg::VoltW-1:0] volt_uv;
  logic signed [phc_pkg::TempW-1:0] temp_cc;
  logic                             temp_ok;

  modport source (output valid, output volt_uv, output temp_cc, output temp_ok, input ready);
  modport sink   (input valid, input volt_uv, input temp_cc, input temp_ok, output ready);
endinterface

// result channel
interface phc_out_if;
  logic                      valid;
  logic                      ready;
  logic [phc_pkg::PhW-1:0]   ph_milli;
  logic [phc_pkg::StW-1:0]   status;

  modport source (output valid, output ph_milli, output status, input ready);
  modport sink   (input valid, input ph_milli, input status, output ready);
endinterface
`default_nettype wire

FILE: design/ph_from_voltage_calibrated.sv
`default_nettype none
// calibrated pH meter: electrode voltage and water temperature in, pH out
// in_ch carries volt_uv (uV), temp_cc (centi-degC) and temp_ok; when temp_ok
// is low the calibration temperature is used instead
// out_ch carries ph_milli (0..14000) and status (0 ok, 1 voltage outside
// 0..2.5 V, 2 degenerate three-point fit); ph_milli is 0 for nonzero status
// the APB port holds three (voltage, pH) calibration points and the
// calibration temperature at byte addresses 0..24; write only while idle
// an accepted transaction passes the front stages for the fit products and
// temperature scaling, one overflow test, fourteen one-bit restoring divide
// stages, and the output register on its way to the result
// throughput is one transaction per cycle while the receiver takes results;
// every stage is registered and empty stages fill while the output stalls,
// so a stalled receiver only holds back input once the whole pipeline is full
// the fitted line is recomputed from the registers in registered fit stages
// reset empties the pipeline and restores the calibration defaults
module ph_from_voltage_calibrated (
  input  wire logic        clk,
  input  wire logic        rst_n,
  phc_in_if.sink           in_ch,
  phc_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  phc_pkg::phc_fit_t         fit;
  phc_pkg::phc_flags_t       flags;
  logic                      mid_valid;
  logic                      mid_ready;
  logic [phc_pkg::DivXW-1:0] mid_x;
  logic [phc_pkg::DivYW-1:0] mid_y;

  // configuration registers and line fit
  phc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fit     (fit)
  );

  // numerator and divisor
  phc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .volt_uv   (in_ch.volt_uv),
    .temp_cc   (in_ch.temp_cc),
    .temp_ok   (in_ch.temp_ok),
    .fit       (fit),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .x_out     (mid_x),
    .y_out     (mid_y),
    .flags_out (flags)
  );

  // divide, clamp and result register
  phc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .x_in      (mid_x),
    .y_in      (mid_y),
    .flags_in  (flags),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ph_milli  (out_ch.ph_milli),
    .status    (out_ch.status)
  );

endmodule
`default_nettype wire

FILE: design/phc_cfg.sv
`default_nettype none
module phc_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output phc_pkg::phc_fit_t      fit
);

  logic [phc_pkg::CalVW-1:0] cal_v_r [0:2];
  logic [phc_pkg::CalPW-1:0] cal_p_r [0:2];
  logic [phc_pkg::TempW-1:0] cal_t_r;
  logic [2:0]                idx;
  logic                      wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_v_r[0] <= 22'd2000000;
      cal_p_r[0] <= 14'd4000;
      cal_v_r[1] <= 22'd1500000;
      cal_p_r[1] <= 14'd7000;
      cal_v_r[2] <= 22'd1000000;
      cal_p_r[2] <= 14'd10000;
      cal_t_r    <= 15'd2500;
    end else if (wr) begin
      unique case (idx)
        phc_pkg::REG_VOLT_1:   cal_v_r[0] <= pwdata[phc_pkg::CalVW-1:0];
        phc_pkg::REG_PH_1:     cal_p_r[0] <= pwdata[phc_pkg::CalPW-1:0];
        phc_pkg::REG_VOLT_2:   cal_v_r[1] <= pwdata[phc_pkg::CalVW-1:0];
        phc_pkg::REG_PH_2:     cal_p_r[1] <= pwdata[phc_pkg::CalPW-1:0];
        phc_pkg::REG_VOLT_3:   cal_v_r[2] <= pwdata[phc_pkg::CalVW-1:0];
        phc_pkg::REG_PH_3:     cal_p_r[2] <= pwdata[phc_pkg::CalPW-1:0];
        phc_pkg::REG_CAL_TEMP: cal_t_r    <= pwdata[phc_pkg::TempW-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      phc_pkg::REG_VOLT_1:   prdata = {10'b0, cal_v_r[0]};
      phc_pkg::REG_PH_1:     prdata = {18'b0, cal_p_r[0]};
      phc_pkg::REG_VOLT_2:   prdata = {10'b0, cal_v_r[1]};
      phc_pkg::REG_PH_2:     prdata = {18'b0, cal_p_r[1]};
      phc_pkg::REG_VOLT_3:   prdata = {10'b0, cal_v_r[2]};
      phc_pkg::REG_PH_3:     prdata = {18'b0, cal_p_r[2]};
      phc_pkg::REG_CAL_TEMP: prdata = {17'b0, cal_t_r};
      default:               prdata = '0;
    endcase
  end

  // pairwise differences and their products, one per point pair
  logic        [28:0] sq_nxt [0:2];
  logic signed [37:0] pr_nxt [0:2];
  logic        [28:0] sq_r   [0:2];
  logic signed [37:0] pr_r   [0:2];

  always_comb begin
    logic signed [14:0] dp;
    logic signed [22:0] dv;
    logic signed [29:0] sq;
    int ia;
    int ib;
    for (int i = 0; i < 3; i++) begin
      ia = (i == 2) ? 1 : 0;
      ib = (i == 0) ? 1 : 2;
      dp = $signed({1'b0, cal_p_r[ia]}) - $signed({1'b0, cal_p_r[ib]});
      dv = $signed({1'b0, cal_v_r[ia]}) - $signed({1'b0, cal_v_r[ib]});
      sq = dp * dp;
      sq_nxt[i] = sq[28:0];
      pr_nxt[i] = dp * dv;
    end
  end

  // first fit stage: products, point sums, calibration temperature
  logic [phc_pkg::SpW-1:0] sp_r;
  logic [phc_pkg::SvW-1:0] sv_r;
  logic [phc_pkg::KW-1:0]  ck_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_nxt[i];
      pr_r[i] <= pr_nxt[i];
    end
    sp_r <= 16'(cal_p_r[0]) + 16'(cal_p_r[1]) + 16'(cal_p_r[2]);
    sv_r <= 24'(cal_v_r[0]) + 24'(cal_v_r[1]) + 24'(cal_v_r[2]);
    ck_r <= {cal_t_r[phc_pkg::TempW-1], cal_t_r} + phc_pkg::KELVIN_CC;
  end

  // second fit stage: D and N as sums of pair terms
  logic        [phc_pkg::DW-1:0] d_r;
  logic signed [phc_pkg::NW-1:0] n_r;

  always_ff @(posedge clk) begin
    d_r <= 30'(sq_r[0]) + 30'(sq_r[1]) + 30'(sq_r[2]);
    n_r <= 39'(pr_r[0]) + 39'(pr_r[1]) + 39'(pr_r[2]);
  end

  assign fit.d  = d_r;
  assign fit.n  = n_r;
  assign fit.sp = sp_r;
  assign fit.sv = sv_r;
  assign fit.ck = ck_r;

endmodule
`default_nettype wire

FILE: design/phc_front.sv
`default_nettype none
module phc_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [phc_pkg::VoltW-1:0] volt_uv,
  input  wire logic signed [phc_pkg::TempW-1:0] temp_cc,
  input  wire logic                             temp_ok,
  input  wire phc_pkg::phc_fit_t                fit,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [phc_pkg::DivXW-1:0]             x_out,
  output logic [phc_pkg::DivYW-1:0]             y_out,
  output phc_pkg::phc_flags_t                   flags_out
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage advance, bubbles collapse
  assign adv5     = !v5_r || out_ready;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // stage 1: capture sample, absolute sample temperature
  logic signed [phc_pkg::VoltW-1:0] volt1_r;
  logic        [phc_pkg::KW-1:0]    tk1_r;
  logic                             ok1_r;
  logic        [phc_pkg::KW-1:0]    tk_nxt;

  assign tk_nxt = {temp_cc[phc_pkg::TempW-1], temp_cc} + phc_pkg::KELVIN_CC;

  always_ff @(posedge clk) begin
    if (adv1) begin
      volt1_r <= volt_uv;
      tk1_r   <= tk_nxt;
      ok1_r   <= temp_ok;
    end
  end

  // stage 2: range check, 3*V - sum(v), temperature select
  logic [23:0]                    v3;
  logic signed [phc_pkg::XW-1:0]  x2_nxt;
  logic signed [phc_pkg::XW-1:0]  x2_r;
  logic                           oor2_r;
  logic [phc_pkg::KW-1:0]         tk2_r;

  assign v3     = {1'b0, volt1_r[21:0], 1'b0} + {2'b0, volt1_r[21:0]};
  assign x2_nxt = $signed({2'b0, v3}) - $signed({2'b0, fit.sv});

  always_ff @(posedge clk) begin
    if (adv2) begin
      x2_r   <= x2_nxt;
      oor2_r <= volt1_r[23] || (volt1_r[22:0] > {1'b0, phc_pkg::VOLT_MAX_UV});
      tk2_r  <= ok1_r ? tk1_r : fit.ck;
    end
  end

  // stage 3: the two numerator products, degenerate fit test
  logic signed [phc_pkg::NumW-1:0] p1_nxt, p2_nxt;
  logic signed [phc_pkg::NumW-1:0] p1_r, p2_r;
  logic signed [phc_pkg::DW:0]     d_s;
  logic signed [phc_pkg::SpW:0]    sp_s;
  logic                            oor3_r, deg3_r;
  logic [phc_pkg::KW-1:0]          tk3_r;

  assign d_s    = $signed({1'b0, fit.d});
  assign sp_s   = $signed({1'b0, fit.sp});
  assign p1_nxt = d_s * x2_r;
  assign p2_nxt = fit.n * sp_s;

  always_ff @(posedge clk) begin
    if (adv3) begin
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      oor3_r <= oor2_r;
      deg3_r <= (fit.d == '0) || (fit.n == '0);
      tk3_r  <= tk2_r;
    end
  end

  // stage 4: numerator sum, sign test, magnitudes
  logic signed [phc_pkg::NumW-1:0] num;
  logic signed [phc_pkg::NumW-1:0] num_neg;
  logic signed [phc_pkg::NW-1:0]   n_neg;
  logic [37:0]                     n_abs;
  logic [phc_pkg::AW-1:0]          an4_r;
  logic [phc_pkg::DenW-1:0]        den4_r;
  logic [phc_pkg::KW-1:0]          tk4_r;
  phc_pkg::phc_flags_t             fl4_r;

  assign num     = p1_r + p2_r;
  assign num_neg = -num;
  assign n_neg   = -fit.n;
  assign n_abs   = fit.n[phc_pkg::NW-1] ? n_neg[37:0] : fit.n[37:0];

  always_ff @(posedge clk) begin
    if (adv4) begin
      an4_r      <= num[phc_pkg::NumW-1] ? num_neg[phc_pkg::AW-1:0] : num[phc_pkg::AW-1:0];
      den4_r     <= {2'b0, n_abs} + {1'b0, n_abs, 1'b0};
      tk4_r      <= tk3_r;
      fl4_r.oor  <= oor3_r;
      fl4_r.degen <= deg3_r;
      fl4_r.zero <= (num == '0) || (num[phc_pkg::NumW-1] != fit.n[phc_pkg::NW-1]);
    end
  end

  // stage 5: scale by calibration and sample temperatures
  logic [phc_pkg::DivXW-1:0] x5_r;
  logic [phc_pkg::DivYW-1:0] y5_r;
  phc_pkg::phc_flags_t       fl5_r;

  always_ff @(posedge clk) begin
    if (adv5) begin
      x5_r  <= an4_r * fit.ck;
      y5_r  <= den4_r * tk4_r;
      fl5_r <= fl4_r;
    end
  end

  assign out_valid = v5_r;
  assign x_out     = x5_r;
  assign y_out     = y5_r;
  assign flags_out = fl5_r;

endmodule
`default_nettype wire

FILE: design/phc_div.sv
`default_nettype none
module phc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [phc_pkg::DivXW-1:0] x_in,
  input  wire logic [phc_pkg::DivYW-1:0] y_in,
  input  wire phc_pkg::phc_flags_t       flags_in,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [phc_pkg::PhW-1:0]        ph_milli,
  output logic [phc_pkg::StW-1:0]        status
);

  localparam int NS = phc_pkg::PhW;

  logic [phc_pkg::DivXW-1:0] rem_r [0:NS];
  logic [phc_pkg::DivYW-1:0] y_r   [0:NS];
  logic [NS-1:0]             q_r   [0:NS];
  phc_pkg::phc_flags_t       fl_r  [0:NS];
  logic                      ovf_r [0:NS];
  logic                      v_r   [0:NS];
  logic                      adv   [0:NS+1];
  logic                      vo_r;

  assign adv[NS+1] = !vo_r || out_ready;
  assign in_ready  = adv[0];

  // stage 0: quotient overflow test against divisor * 2^14
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0] <= x_in;
      y_r[0]   <= y_in;
      q_r[0]   <= '0;
      fl_r[0]  <= flags_in;
      ovf_r[0] <= x_in >= {2'b0, y_in, 14'b0};
    end
  end

  assign adv[0] = !v_r[0] || adv[1];

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_bit
    localparam int K = NS - 1 - i;
    logic [phc_pkg::DivXW-1:0] ys;
    logic                      ge;

    assign ys         = {16'b0, y_r[i]} << K;
    assign ge         = rem_r[i] >= ys;
    assign adv[i + 1] = !v_r[i + 1] || adv[i + 2];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i + 1] <= 1'b0;
      end else if (adv[i + 1]) begin
        v_r[i + 1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i + 1]) begin
        rem_r[i + 1] <= ge ? (rem_r[i] - ys) : rem_r[i];
        q_r[i + 1]   <= q_r[i] | ({{(NS-1){1'b0}}, ge} << K);
        y_r[i + 1]   <= y_r[i];
        fl_r[i + 1]  <= fl_r[i];
        ovf_r[i + 1] <= ovf_r[i];
      end
    end
  end

  // output register: exceptions, clamp
  logic [phc_pkg::PhW-1:0] ph_nxt;
  logic [phc_pkg::StW-1:0] st_nxt;
  logic [phc_pkg::PhW-1:0] ph_r;
  logic [phc_pkg::StW-1:0] st_r;

  always_comb begin
    priority if (fl_r[NS].oor) begin
      ph_nxt = '0;
      st_nxt = phc_pkg::ST_RANGE;
    end else if (fl_r[NS].degen) begin
      ph_nxt = '0;
      st_nxt = phc_pkg::ST_DEGEN;
    end else if (fl_r[NS].zero) begin
      ph_nxt = '0;
      st_nxt = phc_pkg::ST_OK;
    end else if (ovf_r[NS] || (q_r[NS] > phc_pkg::PH_MAX)) begin
      ph_nxt = phc_pkg::PH_MAX;
      st_nxt = phc_pkg::ST_OK;
    end else begin
      ph_nxt = q_r[NS];
      st_nxt = phc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv[NS+1]) begin
      vo_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS+1]) begin
      ph_r <= ph_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid = vo_r;
  assign ph_milli  = ph_r;
  assign status    = st_r;

endmodule
`default_nettype wire

FILE: bench/ph_from_voltage_calibrated_tb.sv
module ph_from_voltage_calibrated_tb;

  localparam int LatencyCycles = 25;
  localparam int CycleLimit    = 400000;
  localparam int ItemsPerPhase = 140;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        calm = 1'b0;
  int          cycles = 0;

  phc_in_if  in_ch ();
  phc_out_if out_ch ();

  ph_from_voltage_calibrated DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  typedef struct {
    logic [phc_pkg::PhW-1:0] ph;
    logic [phc_pkg::StW-1:0] st;
  } ph_result_t;

  // calibration registers, fit arithmetic and pending pH results
  class ph_scoreboard;
    logic [phc_pkg::CalVW-1:0]        cal_volt[3];
    logic [phc_pkg::CalPW-1:0]        cal_ph[3];
    logic signed [phc_pkg::TempW-1:0] cal_temp;
    ph_result_t                       pending_ph[$];
    int                               errors;

    function void restore_defaults();
      cal_volt[0] = 22'd2000000; cal_ph[0] = 14'd4000;
      cal_volt[1] = 22'd1500000; cal_ph[1] = 14'd7000;
      cal_volt[2] = 22'd1000000; cal_ph[2] = 14'd10000;
      cal_temp = 15'sd2500;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        phc_pkg::REG_VOLT_1:   cal_volt[0] = val[phc_pkg::CalVW-1:0];
        phc_pkg::REG_PH_1:     cal_ph[0]   = val[phc_pkg::CalPW-1:0];
        phc_pkg::REG_VOLT_2:   cal_volt[1] = val[phc_pkg::CalVW-1:0];
        phc_pkg::REG_PH_2:     cal_ph[1]   = val[phc_pkg::CalPW-1:0];
        phc_pkg::REG_VOLT_3:   cal_volt[2] = val[phc_pkg::CalVW-1:0];
        phc_pkg::REG_PH_3:     cal_ph[2]   = val[phc_pkg::CalPW-1:0];
        phc_pkg::REG_CAL_TEMP: cal_temp    = val[phc_pkg::TempW-1:0];
        default: ;
      endcase
    endfunction

    // least-squares line, temperature scaled slope, truncation and clamp
    function ph_result_t predict(logic signed [phc_pkg::VoltW-1:0] v_in,
                                 logic signed [phc_pkg::TempW-1:0] t_in, logic t_ok);
      ph_result_t          res;
      longint              volt, temp_c, sp, sv, spv, sp2, d, n, num, tk, ck;
      longint unsigned     an, den1, q, r, t, ph;
      volt = v_in;
      temp_c = t_ok ? longint'(t_in) : longint'(cal_temp);
      res.ph = '0;
      res.st = phc_pkg::ST_OK;
      if (volt < 0 || volt > 2500000) begin
        res.st = phc_pkg::ST_RANGE;
        return res;
      end
      sp = 0; sv = 0; spv = 0; sp2 = 0;
      for (int i = 0; i < 3; i++) begin
        sp  += longint'(cal_ph[i]);
        sv  += longint'(cal_volt[i]);
        spv += longint'(cal_ph[i]) * longint'(cal_volt[i]);
        sp2 += longint'(cal_ph[i]) * longint'(cal_ph[i]);
      end
      d = 3 * sp2 - sp * sp;
      n = 3 * spv - sp * sv;
      if (d == 0 || n == 0) begin
        res.st = phc_pkg::ST_DEGEN;
        return res;
      end
      num = 3 * d * volt - d * sv + n * sp;
      if (num == 0 || ((num < 0) != (n < 0))) return res;
      tk = temp_c + 27315;
      ck = longint'(cal_temp) + 27315;
      an = (num < 0) ? longint'(-num) : num;
      den1 = 3 * ((n < 0) ? longint'(-n) : n);
      q = an / den1;
      r = an % den1;
      if (q >= 64'd1048576) begin
        res.ph = phc_pkg::PH_MAX;
        return res;
      end
      t = q * longint'(ck) + (r * longint'(ck)) / den1;
      ph = t / longint'(tk);
      if (ph > 14000) ph = 14000;
      res.ph = ph[phc_pkg::PhW-1:0];
      return res;
    endfunction

    function void note_sample(logic signed [phc_pkg::VoltW-1:0] v,
                              logic signed [phc_pkg::TempW-1:0] tc, logic ok);
      pending_ph.push_back(predict(v, tc, ok));
    endfunction

    function void check_result(logic [phc_pkg::PhW-1:0] ph, logic [phc_pkg::StW-1:0] st);
      ph_result_t exp_r;
      if (pending_ph.size() == 0) begin
        $error("unexpected result ph_milli=%0d status=%0d", ph, st);
        errors++;
        return;
      end
      exp_r = pending_ph.pop_front();
      if (st !== exp_r.st) begin
        $error("status mismatch: expected %0d actual %0d", exp_r.st, st);
        errors++;
      end
      if (ph !== exp_r.ph) begin
        $error("ph_milli mismatch: expected %0d actual %0d", exp_r.ph, ph);
        errors++;
      end
    endfunction
  endclass

  ph_scoreboard ph_sb = new();

  always #5 clk = ~clk;

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ph_from_voltage_calibrated regression: fail");
      $finish;
    end
  end

  // accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      ph_sb.note_sample(in_ch.volt_uv, in_ch.temp_cc, in_ch.temp_ok);
    if (rst_n && out_ch.valid && out_ch.ready)
      ph_sb.check_result(out_ch.ph_milli, out_ch.status);
  end

  // receiver stalls in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    ph_sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_cal(int v1, int p1, int v2, int p2, int v3, int p3, int ct);
    reg_write(phc_pkg::REG_VOLT_1, v1);
    reg_write(phc_pkg::REG_PH_1, p1);
    reg_write(phc_pkg::REG_VOLT_2, v2);
    reg_write(phc_pkg::REG_PH_2, p2);
    reg_write(phc_pkg::REG_VOLT_3, v3);
    reg_write(phc_pkg::REG_PH_3, p3);
    reg_write(phc_pkg::REG_CAL_TEMP, ct);
  endtask

  // one sample transaction, optional random gap before it
  task automatic send_sample(logic signed [phc_pkg::VoltW-1:0] v,
                             logic signed [phc_pkg::TempW-1:0] tc, logic ok);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.volt_uv <= v;
    in_ch.temp_cc <= tc;
    in_ch.temp_ok <= ok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random();
    logic signed [phc_pkg::VoltW-1:0] v;
    logic signed [phc_pkg::TempW-1:0] tc;
    case ($urandom_range(0, 9))
      0:       v = phc_pkg::VoltW'($urandom());
      1:       v = $urandom_range(0, 1) ? -24'sd1 : 24'sd2500001;
      default: v = phc_pkg::VoltW'($urandom_range(0, 2500000));
    endcase
    if ($urandom_range(0, 4) == 0) tc = phc_pkg::TempW'($urandom());
    else tc = phc_pkg::TempW'($signed($urandom_range(0, 16500)) - 4000);
    send_sample(v, tc, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (ph_sb.pending_ph.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  // plausible electrode line with random slope, offset and buffers
  task automatic load_random_line();
    int k, off, p1, p2, p3;
    k   = $urandom_range(30, 80);
    off = $urandom_range(1000000, 1500000);
    p1  = $urandom_range(0, 14000);
    p2  = $urandom_range(0, 14000);
    p3  = $urandom_range(0, 14000);
    load_cal(off - k * (p1 - 7000), p1, off - k * (p2 - 7000), p2,
             off - k * (p3 - 7000), p3, $signed($urandom_range(0, 16500)) - 4000);
  endtask

  initial begin
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.volt_uv <= '0; in_ch.temp_cc <= '0; in_ch.temp_ok <= 1'b0;
    ph_sb.restore_defaults();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: voltage and temperature extremes on the default calibration
    send_sample(24'sd0, 15'sd2500, 1'b1);
    send_sample(24'sd2500000, 15'sd2500, 1'b1);
    send_sample(-24'sd1, 15'sd2500, 1'b1);
    send_sample(24'sd2500001, 15'sd2500, 1'b1);
    send_sample(24'sh800000, 15'sd0, 1'b0);
    send_sample(24'sd8388607, 15'sd0, 1'b0);
    send_sample(24'sd1500000, 15'sh4000, 1'b1);
    send_sample(24'sd1500000, 15'sd16383, 1'b1);
    send_sample(24'sd1500000, -15'sd4000, 1'b1);
    send_sample(24'sd1500000, 15'sd12500, 1'b1);
    send_sample(24'sd1500000, 15'sd12500, 1'b0);
    send_sample(24'sd1250000, 15'sd2500, 1'b1);
    send_sample(24'sd1750000, -15'sd1, 1'b1);
    drain();

    // directed: flat voltages give a zero slope
    load_cal(1000000, 4000, 1000000, 7000, 1000000, 10000, 2500);
    send_sample(24'sd1000000, 15'sd2500, 1'b1);
    send_sample(24'sd0, 15'sd2500, 1'b0);
    drain();
    // directed: equal buffers give a zero denominator, range test still first
    load_cal(2000000, 7000, 1500000, 7000, 1000000, 7000, 2500);
    send_sample(24'sd1500000, 15'sd2500, 1'b1);
    send_sample(24'sd2500001, 15'sd2500, 1'b1);
    drain();
    // directed: registers beyond their range, unknown register ignored
    load_cal(22'h3FFFFF, 14'h3FFF, 0, 0, 2500000, 14000, -16384);
    reg_write(3'd7, 32'hFFFF_FFFF);
    send_sample(24'sd2000000, 15'sd16383, 1'b1);
    send_sample(24'sd0, 15'sd0, 1'b0);
    drain();
    load_cal(0, 14000, 2500000, 0, 1250000, 7000, 16383);
    send_sample(24'sd100000, 15'sh4000, 1'b1);
    send_sample(24'sd2400000, 15'sd0, 1'b0);
    drain();

    // random phases: defaults, extremes, realistic lines
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_cal(2000000, 4000, 1500000, 7000, 1000000, 10000, 2500);
        1: load_cal(2500000, 0, 1250000, 7000, 0, 14000, -4000);
        2: load_cal(0, 0, 2500000, 14000, 2500000, 14000, 12500);
        default: load_random_line();
      endcase
      if (phase == 4) calm = 1'b1;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (phase >= 3 && i % 35 == 34) begin
          drain();
          load_random_line();
        end
        send_random();
      end
      drain();
    end

    if (ph_sb.errors == 0) begin
      $display("ph_from_voltage_calibrated regression: pass");
    end else begin
      $display("ph_from_voltage_calibrated regression: fail");
    end
    $finish;
  end

endmodule
